@@ hdl/lzsw_pkg.sv @@
package lzsw_pkg;

   // Defaults for the top-level parameters.
   localparam int HISTORY_MAX_DEFAULT   = 256;
   localparam int LOOKAHEAD_MAX_DEFAULT = 16;
   localparam int POS_BITS_DEFAULT      = 32;

   // Fixed field widths.
   localparam int BYTE_W      = 8;
   localparam int HIST_SIZE_W = 9;
   localparam int MAX_MATCH_W = 4;
   localparam int OUT_POS_W   = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   // Register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MATCH    = 1'b1;
   localparam logic [HIST_SIZE_W-1:0] HISTORY_SIZE_RESET = 9'd12;
   localparam logic [MAX_MATCH_W-1:0] MAX_MATCH_RESET    = 4'd9;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } lzsw_entry_type;

   typedef struct packed {
      logic [HIST_SIZE_W-1:0] history_size;
      logic [MAX_MATCH_W-1:0] max_match;
   } lzsw_cfg_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0]   target_pos;
      logic [OUT_POS_W-1:0]   source_pos;
      logic [MAX_MATCH_W-1:0] match_length;
      logic                   stream_end;
   } lzsw_result_type;

endpackage

@@ hdl/lzsw_if.sv @@
interface lzsw_req_if;
   import lzsw_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzsw_rsp_if;
   import lzsw_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OUT_POS_W-1:0]   target_pos;
   logic [OUT_POS_W-1:0]   source_pos;
   logic [MAX_MATCH_W-1:0] match_length;
   logic                   stream_end;

   modport source (output valid, output target_pos, output source_pos,
                   output match_length, output stream_end, input ready);
   modport sink   (input valid, input target_pos, input source_pos,
                   input match_length, input stream_end, output ready);
endinterface

@@ hdl/lzsw_ram.sv @@
module lzsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

@@ hdl/lzsw_front.sv @@
module lzsw_front (
   input  logic                     clock,
   input  logic                     reset,
   lzsw_req_if.sink                 req_ch,
   input  logic                     pop,
   output lzsw_pkg::lzsw_entry_type entry,
   output logic                     entry_valid
);
   import lzsw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lzsw_entry_type    queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              do_pop;

   // The front takes an item whenever the queue has room.
   assign req_ch.ready = (32'(count_ff) < 32'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign entry_valid  = (count_ff != '0);
   assign do_pop       = pop && entry_valid;
   assign entry        = queue_ff[rd_ptr_ff];

   // Pointer and count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The entry records the byte and whether it closes the stream.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{data_byte: req_ch.data_byte, last_byte: req_ch.last_byte};
      end
   end

endmodule

@@ hdl/lzsw_back.sv @@
module lzsw_back #(
   parameter int HISTORY_MAX   = lzsw_pkg::HISTORY_MAX_DEFAULT,
   parameter int LOOKAHEAD_MAX = lzsw_pkg::LOOKAHEAD_MAX_DEFAULT,
   parameter int POS_BITS      = lzsw_pkg::POS_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lzsw_pkg::lzsw_cfg_type   cfg,
   input  lzsw_pkg::lzsw_entry_type entry,
   input  logic                     entry_valid,
   output logic                     pop,
   lzsw_rsp_if.source               rsp_ch
);
   import lzsw_pkg::*;

   localparam int D_W       = $clog2(HISTORY_MAX + 1);
   localparam int L_W       = $clog2(LOOKAHEAD_MAX + 1);
   localparam int ADDR_W    = $clog2(HISTORY_MAX + LOOKAHEAD_MAX);
   localparam int RAM_DEPTH = 1 << ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_COMPARE,
      ST_PHRASE
   } state_type;

   state_type             state_ff, state_in;
   logic                  last_ff, last_in;
   logic [D_W-1:0]        hist_fill_ff, hist_fill_in;
   logic [L_W-1:0]        look_fill_ff, look_fill_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [D_W-1:0]        dist_ff, dist_in;
   logic [L_W-1:0]        idx_ff, idx_in;
   logic [L_W-1:0]        lim_ff, lim_in;
   logic [L_W-1:0]        best_ff, best_in;
   logic [D_W-1:0]        best_d_ff, best_d_in;
   logic                  hold_valid_ff, hold_valid_in;
   lzsw_result_type       hold_ff, hold_in;
   logic                  out_valid_ff, out_valid_in;
   lzsw_result_type       out_ff, out_in;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [ADDR_W-1:0]     ram_raddr_a;
   logic [ADDR_W-1:0]     ram_raddr_b;
   logic [BYTE_W-1:0]     ram_rdata_a;
   logic [BYTE_W-1:0]     ram_rdata_b;

   logic [31:0]           hs32;
   logic [31:0]           cap32;
   logic [31:0]           lim32;
   logic [31:0]           hist_sel32;
   logic [31:0]           adv32;
   logic [31:0]           new_hist32;
   logic [31:0]           run32;
   logic [31:0]           best32;
   logic [63:0]           tpos64;
   logic [63:0]           spos64;
   logic                  need_phrase;
   logic                  out_free;
   lzsw_result_type       rule;
   lzsw_result_type       marker;

   // Window ring: the phrase starts at head, history lies below it.
   lzsw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_window (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (entry.data_byte),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   // Limits derived from the registers.
   always_comb begin
      hs32  = ({23'b0, cfg.history_size} > 32'(HISTORY_MAX)) ?
              32'(HISTORY_MAX) : {23'b0, cfg.history_size};
      cap32 = ({28'b0, cfg.max_match} + 32'd1 > 32'(LOOKAHEAD_MAX)) ?
              32'(LOOKAHEAD_MAX) : {28'b0, cfg.max_match} + 32'd1;
      lim32 = (32'(look_fill_ff) < {28'b0, cfg.max_match}) ?
              32'(look_fill_ff) : {28'b0, cfg.max_match};
      hist_sel32 = (32'(hist_fill_ff) < hs32) ? 32'(hist_fill_ff) : hs32;
      adv32 = (32'(best_ff) + 32'd1 > 32'(look_fill_ff)) ?
              32'(look_fill_ff) : 32'(best_ff) + 32'd1;
      new_hist32 = (32'(hist_fill_ff) + adv32 > hs32) ? hs32 : 32'(hist_fill_ff) + adv32;
      best32 = 32'(best_ff);
      run32  = (ram_rdata_a == ram_rdata_b) ? 32'(idx_ff) + 32'd1 : 32'(idx_ff);
      tpos64 = 64'(pos_ff);
      spos64 = 64'(pos_ff - POS_BITS'(best_d_ff));
   end

   assign need_phrase = last_ff ? (look_fill_ff != '0) :
                        ((32'(look_fill_ff) >= cap32) && (look_fill_ff != '0));
   assign out_free    = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      rule.target_pos   = tpos64[OUT_POS_W-1:0];
      rule.source_pos   = spos64[OUT_POS_W-1:0];
      rule.match_length = best32[MAX_MATCH_W-1:0];
      rule.stream_end   = 1'b0;
      marker.target_pos   = tpos64[OUT_POS_W-1:0];
      marker.source_pos   = '0;
      marker.match_length = '0;
      marker.stream_end   = 1'b1;
   end

   assign ram_waddr   = head_ff + ADDR_W'(look_fill_ff);
   assign ram_raddr_a = head_ff - ADDR_W'(dist_ff) + ADDR_W'(idx_ff);
   assign ram_raddr_b = head_ff + ADDR_W'(idx_ff);

   // Search sequencer: each compare issues two reads and checks them in the next cycle.
   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      hist_fill_in  = hist_fill_ff;
      look_fill_in  = look_fill_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      dist_in       = dist_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      best_in       = best_ff;
      best_d_in     = best_d_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_in        = out_ff;
      ram_we        = 1'b0;
      pop           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               pop          = 1'b1;
               ram_we       = 1'b1;
               look_fill_in = look_fill_ff + 1'b1;
               last_in      = entry.last_byte;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (need_phrase) begin
               dist_in   = hist_sel32[D_W-1:0];
               idx_in    = '0;
               best_in   = '0;
               best_d_in = '0;
               lim_in    = lim32[L_W-1:0];
               state_in  = (hist_sel32 == 32'd0 || lim32 == 32'd0) ? ST_PHRASE : ST_READ;
            end else if (out_free) begin
               // The held rule, if any, leaves now; on the final item it closes the stream, else an end marker does.
               if (last_ff) begin
                  out_valid_in = 1'b1;
                  if (hold_valid_ff) begin
                     out_in            = hold_ff;
                     out_in.stream_end = 1'b1;
                  end else begin
                     out_in = marker;
                  end
                  hist_fill_in = '0;
                  look_fill_in = '0;
                  pos_in       = '0;
               end else if (hold_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in       = hold_ff;
               end
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if ((ram_rdata_a == ram_rdata_b) && (32'(idx_ff) + 32'd1 < 32'(lim_ff))) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               // Strictly longer only, so the farthest distance wins a tie.
               if (run32 > best32) begin
                  best_in   = run32[L_W-1:0];
                  best_d_in = dist_ff;
               end
               if (dist_ff == D_W'(1)) begin
                  state_in = ST_PHRASE;
               end else begin
                  dist_in  = dist_ff - 1'b1;
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_PHRASE: begin
            if ((best_ff == '0) || !hold_valid_ff || out_free) begin
               if (best_ff != '0) begin
                  if (hold_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = hold_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_in       = rule;
               end
               hist_fill_in = new_hist32[D_W-1:0];
               look_fill_in = look_fill_ff - adv32[L_W-1:0];
               pos_in       = pos_ff + POS_BITS'(adv32);
               head_in      = head_ff + ADDR_W'(adv32);
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= 1'b0;
         hist_fill_ff  <= '0;
         look_fill_ff  <= '0;
         pos_ff        <= '0;
         head_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         hist_fill_ff  <= hist_fill_in;
         look_fill_ff  <= look_fill_in;
         pos_ff        <= pos_in;
         head_ff       <= head_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      dist_ff   <= dist_in;
      idx_ff    <= idx_in;
      lim_ff    <= lim_in;
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      hold_ff   <= hold_in;
      out_ff    <= out_in;
   end

   // Result channel driven from the output register.
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.target_pos   = out_ff.target_pos;
   assign rsp_ch.source_pos   = out_ff.source_pos;
   assign rsp_ch.match_length = out_ff.match_length;
   assign rsp_ch.stream_end   = out_ff.stream_end;

endmodule

@@ hdl/lz77_sliding_window_matcher.sv @@
// Channel   Ports            Direction  Carries
// request   req_ch (sink)    in         data_byte, last_byte
// response  rsp_ch (source)  out        target_pos, source_pos, match_length, stream_end
// config    csr_*            in         history_size (index 0), max_match (index 1)
//
// An item enters through the idle and check states; each phrase it completes then steps
// through a read and a compare state per compared byte and ends in the phrase state.
// Each compare uses the single window memory read pair.
// Reset is synchronous; no clearing pass is needed, the window is never read unwritten.
// A two-entry queue keeps accepting while the search or the output stalls, until it is full.

module lz77_sliding_window_matcher #(
   parameter int HISTORY_MAX   = lzsw_pkg::HISTORY_MAX_DEFAULT,
   parameter int LOOKAHEAD_MAX = lzsw_pkg::LOOKAHEAD_MAX_DEFAULT,
   parameter int POS_BITS      = lzsw_pkg::POS_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lzsw_req_if.sink                              req_ch,
   lzsw_rsp_if.source                            rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [lzsw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lzsw_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import lzsw_pkg::*;

   lzsw_cfg_type   cfg_ff, cfg_in;
   lzsw_entry_type entry;
   logic           entry_valid;
   logic           pop;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HISTORY_SIZE: cfg_in.history_size = csr_write_data[HIST_SIZE_W-1:0];
            CSR_MAX_MATCH:    cfg_in.max_match    = csr_write_data[MAX_MATCH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.history_size <= HISTORY_SIZE_RESET;
         cfg_ff.max_match    <= MAX_MATCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lzsw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .pop         (pop),
      .entry       (entry),
      .entry_valid (entry_valid)
   );

   lzsw_back #(
      .HISTORY_MAX   (HISTORY_MAX),
      .LOOKAHEAD_MAX (LOOKAHEAD_MAX),
      .POS_BITS      (POS_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry       (entry),
      .entry_valid (entry_valid),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

@@ hdl/lzsw_checker.sv @@
module lzsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_target_pos,
   input logic [31:0] rsp_source_pos,
   input logic [3:0]  rsp_match_length,
   input logic        rsp_stream_end
);

   // No result is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_pos)
         && $stable(rsp_source_pos) && $stable(rsp_match_length) && $stable(rsp_stream_end))
      else $error("stalled result changed");

   // Only the end marker carries a zero length.
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stream_end |-> rsp_match_length != 4'd0)
      else $error("rule with zero length");

   // A rule always copies from a position other than its own.
   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_length != 4'd0 |-> rsp_source_pos != rsp_target_pos)
      else $error("rule with zero distance");

   // A bare end marker has source position zero.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end && rsp_match_length == 4'd0 |-> rsp_source_pos == 32'd0)
      else $error("end marker with a source position");

endmodule

bind lz77_sliding_window_matcher lzsw_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_target_pos   (rsp_ch.target_pos),
   .rsp_source_pos   (rsp_ch.source_pos),
   .rsp_match_length (rsp_ch.match_length),
   .rsp_stream_end   (rsp_ch.stream_end)
);

@@ sim/tb_lz77_sliding_window_matcher.sv @@
`timescale 1ns / 100ps

import lzsw_pkg::*;

// Holds the expected LZ77 rules and a copy of the matcher's window state.
class phrase_scoreboard;
   localparam int WIN_DEPTH = HISTORY_MAX_DEFAULT + LOOKAHEAD_MAX_DEFAULT;

   bit [BYTE_W-1:0]      win [WIN_DEPTH];
   int unsigned          hist_fill;
   int unsigned          look_fill;
   bit [OUT_POS_W-1:0]   phrase_pos;
   int unsigned          hist_size;
   int unsigned          max_len;
   lzsw_result_type      expected_rules [$];
   int                   mismatches;
   int                   rules_seen;

   function void clear_stream();
      hist_fill  = 0;
      look_fill  = 0;
      phrase_pos = '0;
   endfunction

   function void power_up();
      clear_stream();
      hist_size  = 32'(HISTORY_SIZE_RESET);
      max_len    = 32'(MAX_MATCH_RESET);
      mismatches = 0;
      rules_seen = 0;
   endfunction

   function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_HISTORY_SIZE)
         hist_size = 32'(val);
      else
         max_len = 32'(val[MAX_MATCH_W-1:0]);
   endfunction

   function int unsigned hist_limit();
      return (hist_size > HISTORY_MAX_DEFAULT) ? HISTORY_MAX_DEFAULT : hist_size;
   endfunction

   function int unsigned look_cap();
      return (max_len + 1 > LOOKAHEAD_MAX_DEFAULT) ? LOOKAHEAD_MAX_DEFAULT : max_len + 1;
   endfunction

   // Finds the longest match, farthest distance on ties, and advances the window.
   function int search_phrase();
      int unsigned hs, span, base, lim, best, best_d, j, adv, drop;
      lzsw_result_type r;
      hs     = hist_limit();
      span   = (hist_fill < hs) ? hist_fill : hs;
      base   = hist_fill;
      lim    = (look_fill < max_len) ? look_fill : max_len;
      best   = 0;
      best_d = 0;
      for (int unsigned d = span; d > 0; d--) begin
         for (j = 0; j < lim; j++)
            if (win[base - d + j] != win[base + j])
               break;
         if (j > best) begin
            best   = j;
            best_d = d;
         end
      end
      adv = best + 1;
      if (adv > look_fill)
         adv = look_fill;
      hist_fill += adv;
      look_fill -= adv;
      if (hist_fill > hs) begin
         drop = hist_fill - hs;
         for (int unsigned k = 0; k < hs + look_fill; k++)
            win[k] = win[k + drop];
         hist_fill = hs;
      end
      r.target_pos   = phrase_pos;
      r.source_pos   = phrase_pos - best_d;
      r.match_length = best[MAX_MATCH_W-1:0];
      r.stream_end   = 1'b0;
      phrase_pos     = phrase_pos + adv;
      if (best == 0)
         return 0;
      expected_rules.insert(expected_rules.size(), r);
      return 1;
   endfunction

   // Notes one accepted byte and queues the rules it completes.
   function void note_byte(lzsw_entry_type e);
      int n;
      int unsigned slot;
      lzsw_result_type r;
      n    = 0;
      slot = hist_fill + look_fill;
      if (slot < WIN_DEPTH && look_fill < LOOKAHEAD_MAX_DEFAULT) begin
         win[slot] = e.data_byte;
         look_fill++;
      end
      if (!e.last_byte) begin
         while (look_fill >= look_cap() && look_fill > 0)
            n += search_phrase();
         return;
      end
      while (look_fill > 0)
         n += search_phrase();
      if (n > 0) begin
         r = expected_rules[$];
         r.stream_end = 1'b1;
         expected_rules[expected_rules.size() - 1] = r;
      end else begin
         r.target_pos   = phrase_pos;
         r.source_pos   = '0;
         r.match_length = '0;
         r.stream_end   = 1'b1;
         expected_rules.insert(expected_rules.size(), r);
      end
      clear_stream();
   endfunction

   // Compares one transfer on the result channel with the oldest expectation.
   function void check_rule(lzsw_result_type got);
      lzsw_result_type exp_r;
      rules_seen++;
      if (expected_rules.size() == 0) begin
         $display("%0t: rule expected none actual %h", $time, got);
         mismatches++;
         return;
      end
      exp_r = expected_rules[0];
      expected_rules.delete(0);
      if (got.target_pos !== exp_r.target_pos) begin
         $display("%0t: target_pos expected %0d actual %0d", $time,
                  exp_r.target_pos, got.target_pos);
         mismatches++;
      end
      if (got.source_pos !== exp_r.source_pos) begin
         $display("%0t: source_pos expected %0d actual %0d", $time,
                  exp_r.source_pos, got.source_pos);
         mismatches++;
      end
      if (got.match_length !== exp_r.match_length) begin
         $display("%0t: match_length expected %0d actual %0d", $time,
                  exp_r.match_length, got.match_length);
         mismatches++;
      end
      if (got.stream_end !== exp_r.stream_end) begin
         $display("%0t: stream_end expected %0d actual %0d", $time,
                  exp_r.stream_end, got.stream_end);
         mismatches++;
      end
   endfunction
endclass

module tb_lz77_sliding_window_matcher;
   localparam int STALL_LIMIT = 200000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   lzsw_req_if req_ch ();
   lzsw_rsp_if rsp_ch ();

   phrase_scoreboard rules = new();
   bit               calm;
   int               stall_count = 0;
   int               bytes_sent;
   int               settings_used;
   bit [BYTE_W-1:0]  recent [$];

   lz77_sliding_window_matcher uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // The receiver stalls now and then, except during the calm stretch.
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 11);
   end

   // Monitor both channels and count cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            rules.note_byte({req_ch.data_byte, req_ch.last_byte});
         if (rsp_ch.valid && rsp_ch.ready)
            rules.check_rule({rsp_ch.target_pos, rsp_ch.source_pos,
                              rsp_ch.match_length, rsp_ch.stream_end});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offers one byte and holds it until the transfer happens.
   task automatic send_byte(input bit [BYTE_W-1:0] b, input bit last);
      while (!calm && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      bytes_sent++;
      if (last)
         recent.delete();
      else
         recent.insert(recent.size(), b);
      if (recent.size() > 300)
         recent.delete(0);
   endtask

   // Waits until every rule is out and the search has had time to finish.
   task automatic settle();
      int unsigned hs;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rules.expected_rules.size() != 0)
         @(posedge clock);
      hs = rules.hist_limit();
      repeat ((2 * hs * (rules.max_len + 1) + 8) * 4 + 50)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      rules.set_register(idx, val);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input int unsigned hs, input int unsigned mm);
      settle();
      write_register(CSR_HISTORY_SIZE, hs[CSR_DATA_W-1:0]);
      write_register(CSR_MAX_MATCH, mm[CSR_DATA_W-1:0]);
      settings_used++;
   endtask

   // Random bytes shaped so that repeats and copies of recent text are common.
   task automatic send_random(input int count);
      bit [BYTE_W-1:0] b;
      int unsigned d;
      bit last;
      for (int i = 0; i < count; i++) begin
         if (recent.size() > 0 && $urandom_range(99) < 45) begin
            d = $urandom_range(recent.size() < 40 ? recent.size() : 40, 1);
            b = recent[recent.size() - d];
         end else if ($urandom_range(99) < 70) begin
            b = 8'h61 + 8'($urandom_range(2));
         end else begin
            b = 8'($urandom);
         end
         last = ($urandom_range(24) == 0);
         send_byte(b, last);
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            <= 1'b1;
      calm             <= 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_HISTORY_SIZE;
      csr_write_data   <= '0;
      bytes_sent       = 0;
      settings_used    = 1;
      rules.power_up();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset setting: a bare end marker, extreme bytes,
      // an overlapping run, and a stream that ends before the lookahead fills.
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      for (int i = 0; i < 12; i++)
         send_byte(8'h5f, 1'b0);
      send_byte(8'h5f, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);

      // Open stream carried across a register change that shrinks both limits.
      for (int i = 0; i < 6; i++)
         send_byte(8'h30 + 8'(i % 3), 1'b0);
      configure(3, 1);
      send_random(40);

      // Literal-only setting, then no history at all.
      configure(7, 0);
      send_random(20);
      configure(0, 4);
      send_random(15);

      // Largest settings, kept short since every search is long.
      configure(256, 15);
      send_random(20);
      configure(300, 15);
      send_random(10);

      // Further settings, one of them random, with a calm stretch in the middle.
      configure(1, 1);
      send_random(40);
      configure(24, 6);
      send_random(60);
      calm <= 1'b1;
      configure(16, 15);
      send_random(60);
      calm <= 1'b0;
      configure($urandom_range(40, 2), $urandom_range(12, 2));
      send_random(80);
      configure(12, 9);
      send_random(30);
      send_byte(8'h00, 1'b1);

      settle();
      $display("sent %0d bytes over %0d register settings, checked %0d rules",
               bytes_sent, settings_used, rules.rules_seen);
      if (rules.mismatches == 0 && rules.expected_rules.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d rules missing", rules.mismatches,
                  rules.expected_rules.size());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
